// ===== hdl/rsc_pkg.sv =====
// Shared types and constants for the RPN stack calculator core.
// Used by the channel interfaces, the stack RAM user and the shared ALU.
`timescale 1ns / 1ps

package rsc_pkg;

   // Stack geometry and datapath width
   localparam int STACK_DEPTH = 128;
   localparam int DATA_WIDTH  = 32;
   localparam int ADDR_W      = $clog2(STACK_DEPTH);
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
   localparam int ITER_W      = $clog2(DATA_WIDTH);

   // Word field widths
   localparam int CHAR_W  = 8;
   localparam int STAT_W  = 3;
   localparam int VALUE_W = 32;
   localparam int DEPTH_W = 8;

   // Character codes
   localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
   localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
   localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
   localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
   localparam logic [CHAR_W-1:0] CH_EQUAL = 8'h3D;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK      = 3'd0,
      STAT_VALUE   = 3'd1,
      STAT_UNDER   = 3'd2,
      STAT_DIVZERO = 3'd3,
      STAT_OVER    = 3'd4,
      STAT_END     = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      ALU_ADD,
      ALU_SUB,
      ALU_MUL,
      ALU_DIV
   } alu_op_type;

   typedef struct packed {
      logic       start;
      alu_op_type op;
   } alu_ctl_type;

   typedef enum logic [1:0] {
      AST_IDLE,
      AST_RUN,
      AST_FIX
   } alu_state_type;

   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_RD_A,
      SEQ_RD_B,
      SEQ_CALC,
      SEQ_DONE
   } seq_state_type;

   // Sign-extend a stack entry and keep the low bits of the value field
   function automatic logic [VALUE_W-1:0] to_value(input logic [DATA_WIDTH-1:0] d);
      logic signed [63:0] ext;
      ext = 64'($signed(d));
      return ext[VALUE_W-1:0];
   endfunction

endpackage

// ===== hdl/rsc_if.sv =====
// Valid/ready channel interfaces for the RPN stack calculator core.
// Depends on rsc_pkg for the word field widths.
`timescale 1ns / 1ps

interface rsc_req_if import rsc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] char_code;

   modport source (output valid, output char_code, input ready);
   modport sink (input valid, input char_code, output ready);
endinterface

interface rsc_rsp_if import rsc_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [STAT_W-1:0]         status;
   logic signed [VALUE_W-1:0] value;
   logic [DEPTH_W-1:0]        depth;

   modport source (output valid, output status, output value, output depth, input ready);
   modport sink (input valid, input status, input value, input depth, output ready);
endinterface

// ===== hdl/rsc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module rsc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== hdl/rsc_alu.sv =====
// Shared arithmetic unit: registered add/subtract, radix-2 shift-add multiply
// and restoring signed divide iterated over DATA_WIDTH bits. Depends on rsc_pkg.
`timescale 1ns / 1ps

module rsc_alu import rsc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  alu_ctl_type           ctl,
   input  logic [DATA_WIDTH-1:0] lhs,
   input  logic [DATA_WIDTH-1:0] rhs,
   output logic                  done,
   output logic [DATA_WIDTH-1:0] result
);

   alu_state_type           state_ff, state_in;
   alu_op_type              op_ff, op_in;
   logic [ITER_W-1:0]       iter_ff, iter_in;
   logic [DATA_WIDTH-1:0]   acc_ff, acc_in;
   logic [DATA_WIDTH-1:0]   opa_ff, opa_in;
   logic [DATA_WIDTH-1:0]   opb_ff, opb_in;
   logic                    neg_ff, neg_in;
   logic                    done_ff, done_in;
   logic [DATA_WIDTH-1:0]   result_ff, result_in;
   logic [DATA_WIDTH:0]     rem_sh;
   logic [DATA_WIDTH:0]     diff;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= AST_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      iter_ff   <= iter_in;
      acc_ff    <= acc_in;
      opa_ff    <= opa_in;
      opb_ff    <= opb_in;
      neg_ff    <= neg_in;
      result_ff <= result_in;
   end

   // Trial subtract for one divide step
   assign rem_sh = {acc_ff, opb_ff[DATA_WIDTH-1]};
   assign diff   = rem_sh - {1'b0, opa_ff};

   // Sequence the operation
   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      iter_in   = iter_ff;
      acc_in    = acc_ff;
      opa_in    = opa_ff;
      opb_in    = opb_ff;
      neg_in    = neg_ff;
      result_in = result_ff;
      done_in   = 1'b0;

      unique case (state_ff)
         AST_IDLE: begin
            if (ctl.start) begin
               op_in   = ctl.op;
               acc_in  = '0;
               iter_in = ITER_W'(DATA_WIDTH - 1);
               unique case (ctl.op)
                  ALU_ADD: begin
                     result_in = lhs + rhs;
                     done_in   = 1'b1;
                  end
                  ALU_SUB: begin
                     result_in = lhs - rhs;
                     done_in   = 1'b1;
                  end
                  ALU_MUL: begin
                     opa_in   = lhs;
                     opb_in   = rhs;
                     state_in = AST_RUN;
                  end
                  ALU_DIV: begin
                     // divisor and dividend magnitudes, quotient sign
                     opa_in   = rhs[DATA_WIDTH-1] ? -rhs : rhs;
                     opb_in   = lhs[DATA_WIDTH-1] ? -lhs : lhs;
                     neg_in   = lhs[DATA_WIDTH-1] ^ rhs[DATA_WIDTH-1];
                     state_in = AST_RUN;
                  end
               endcase
            end
         end

         AST_RUN: begin
            if (op_ff == ALU_MUL) begin
               // add the shifted multiplicand for each set multiplier bit
               if (opb_ff[0]) begin
                  acc_in = acc_ff + opa_ff;
               end
               opa_in = opa_ff << 1;
               opb_in = opb_ff >> 1;
            end else begin
               // one restoring divide step; quotient bits shift in below
               if (!diff[DATA_WIDTH]) begin
                  acc_in = diff[DATA_WIDTH-1:0];
                  opb_in = {opb_ff[DATA_WIDTH-2:0], 1'b1};
               end else begin
                  acc_in = rem_sh[DATA_WIDTH-1:0];
                  opb_in = {opb_ff[DATA_WIDTH-2:0], 1'b0};
               end
            end
            iter_in = iter_ff - ITER_W'(1);
            if (iter_ff == '0) begin
               state_in = AST_FIX;
            end
         end

         AST_FIX: begin
            if (op_ff == ALU_MUL) begin
               result_in = acc_ff;
            end else begin
               result_in = neg_ff ? -opb_ff : opb_ff;
            end
            done_in  = 1'b1;
            state_in = AST_IDLE;
         end
      endcase
   end

   assign done   = done_ff;
   assign result = result_ff;

endmodule

// ===== hdl/rpn_stack_calculator_core.sv =====
// Reverse Polish calculator: one character per input word, one result word
// per character, over a RAM-backed stack of signed integers. Depends on
// rsc_pkg, rsc_if, rsc_ram and rsc_alu.
//
// Each accepted character yields exactly one result word with status, popped
// value and stack depth. The block takes one character at a time and does not
// accept the next until the result of the last is in the output register;
// multiply and divide run on the shared radix-2 ALU that retires one bit per
// cycle. Operands come one per cycle through the single registered read port
// of the stack RAM. A finished result sits in the output register while the
// next character is accepted; a further result waits until that register is
// taken. The stack RAM is not cleared after reset.
`timescale 1ns / 1ps

module rpn_stack_calculator_core import rsc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   rsc_req_if.sink    req_ch,
   rsc_rsp_if.source  rsp_ch
);

   seq_state_type           state_ff, state_in;
   logic [CHAR_W-1:0]       char_ff, char_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [DATA_WIDTH-1:0]   a_ff, a_in;
   status_type              res_status_ff, res_status_in;
   logic [VALUE_W-1:0]      res_value_ff, res_value_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   status_type              rsp_status_ff, rsp_status_in;
   logic [VALUE_W-1:0]      rsp_value_ff, rsp_value_in;
   logic [DEPTH_W-1:0]      rsp_depth_ff, rsp_depth_in;

   logic                    accept;
   logic                    is_digit;
   logic                    is_op;
   logic                    is_eq;
   logic [CNT_W-1:0]        cnt_m1;
   logic [CNT_W-1:0]        cnt_m2;
   logic [DATA_WIDTH-1:0]   digit_val;

   logic                    ram_we;
   logic [ADDR_W-1:0]       ram_waddr;
   logic [DATA_WIDTH-1:0]   ram_wdata;
   logic [ADDR_W-1:0]       ram_raddr;
   logic [DATA_WIDTH-1:0]   ram_rdata;

   alu_ctl_type             alu_ctl;
   logic                    alu_done;
   logic [DATA_WIDTH-1:0]   alu_result;

   rsc_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   rsc_alu u_alu (
      .clock  (clock),
      .reset  (reset),
      .ctl    (alu_ctl),
      .lhs    (ram_rdata),
      .rhs    (a_ff),
      .done   (alu_done),
      .result (alu_result)
   );

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SEQ_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      char_ff       <= char_in;
      a_ff          <= a_in;
      res_status_ff <= res_status_in;
      res_value_ff  <= res_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_depth_ff  <= rsp_depth_in;
   end

   // Decode the incoming character
   assign accept    = req_ch.valid && req_ch.ready;
   assign is_digit  = (req_ch.char_code >= CH_ZERO) && (req_ch.char_code <= CH_NINE);
   assign is_op     = (req_ch.char_code == CH_PLUS) || (req_ch.char_code == CH_MINUS) ||
                      (req_ch.char_code == CH_STAR) || (req_ch.char_code == CH_SLASH);
   assign is_eq     = (req_ch.char_code == CH_EQUAL);
   assign cnt_m1    = count_ff - CNT_W'(1);
   assign cnt_m2    = count_ff - CNT_W'(2);
   assign digit_val = DATA_WIDTH'(req_ch.char_code - CH_ZERO);

   // Read the top entry by default, the one below it while fetching the first operand
   assign ram_raddr = (state_ff == SEQ_RD_A) ? cnt_m2[ADDR_W-1:0] : cnt_m1[ADDR_W-1:0];

   assign req_ch.ready = (state_ff == SEQ_IDLE);

   // Sequencer: next state, stack update and result word
   always_comb begin
      state_in      = state_ff;
      char_in       = char_ff;
      count_in      = count_ff;
      a_in          = a_ff;
      res_status_in = res_status_ff;
      res_value_in  = res_value_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_depth_in  = rsp_depth_ff;
      ram_we        = 1'b0;
      ram_waddr     = cnt_m2[ADDR_W-1:0];
      ram_wdata     = alu_result;
      alu_ctl.start = 1'b0;
      alu_ctl.op    = ALU_ADD;

      unique case (state_ff)
         SEQ_IDLE: begin
            if (accept) begin
               char_in      = req_ch.char_code;
               res_value_in = '0;
               state_in     = SEQ_DONE;
               if (is_digit) begin
                  // push, or drop on a full stack
                  if (count_ff == CNT_W'(STACK_DEPTH)) begin
                     res_status_in = STAT_OVER;
                  end else begin
                     ram_we        = 1'b1;
                     ram_waddr     = count_ff[ADDR_W-1:0];
                     ram_wdata     = digit_val;
                     count_in      = count_ff + CNT_W'(1);
                     res_status_in = STAT_OK;
                  end
               end else if (is_op) begin
                  if (count_ff < CNT_W'(2)) begin
                     res_status_in = STAT_UNDER;
                  end else begin
                     state_in = SEQ_RD_A;
                  end
               end else if (is_eq) begin
                  if (count_ff == '0) begin
                     res_status_in = STAT_UNDER;
                  end else begin
                     state_in = SEQ_RD_A;
                  end
               end else begin
                  count_in      = '0;
                  res_status_in = STAT_END;
               end
            end
         end

         SEQ_RD_A: begin
            // top of stack is on the read port
            a_in = ram_rdata;
            if (char_ff == CH_EQUAL) begin
               count_in      = cnt_m1;
               res_status_in = STAT_VALUE;
               res_value_in  = to_value(ram_rdata);
               state_in      = SEQ_DONE;
            end else if ((char_ff == CH_SLASH) && (ram_rdata == '0)) begin
               res_status_in = STAT_DIVZERO;
               state_in      = SEQ_DONE;
            end else begin
               state_in = SEQ_RD_B;
            end
         end

         SEQ_RD_B: begin
            // second operand is on the read port: launch the ALU
            alu_ctl.start = 1'b1;
            priority if (char_ff == CH_PLUS) begin
               alu_ctl.op = ALU_ADD;
            end else if (char_ff == CH_MINUS) begin
               alu_ctl.op = ALU_SUB;
            end else if (char_ff == CH_STAR) begin
               alu_ctl.op = ALU_MUL;
            end else begin
               alu_ctl.op = ALU_DIV;
            end
            state_in = SEQ_CALC;
         end

         SEQ_CALC: begin
            // replace the two operands with the result
            if (alu_done) begin
               ram_we        = 1'b1;
               count_in      = cnt_m1;
               res_status_in = STAT_OK;
               state_in      = SEQ_DONE;
            end
         end

         SEQ_DONE: begin
            // hand the word to the output register once it is free
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_value_in  = res_value_ff;
               rsp_depth_in  = DEPTH_W'(count_ff);
               state_in      = SEQ_IDLE;
            end
         end
      endcase
   end

   assign rsp_ch.valid  = rsp_valid_ff;
   assign rsp_ch.status = rsp_status_ff;
   assign rsp_ch.value  = rsp_value_ff;
   assign rsp_ch.depth  = rsp_depth_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(STACK_DEPTH))
      else $error("stack count beyond depth");

   a_no_write_on_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == SEQ_RD_A || state_ff == SEQ_RD_B) |-> !ram_we)
      else $error("stack write during operand fetch");

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && !is_digit && !is_op && !is_eq) |=> (count_ff == '0))
      else $error("end character did not clear the stack");

   a_alu_done_in_calc: assert property (@(posedge clock) disable iff (reset)
      alu_done |-> (state_ff == SEQ_CALC))
      else $error("ALU finished outside the calculate state");
`endif

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for rpn_stack_calculator_core: drives characters,
// predicts each result word from a shadow stack and checks every one.
// Depends on rsc_pkg, rsc_if and the RTL of the core.
`timescale 1ns / 1ps

module tb;
   import rsc_pkg::*;

   typedef struct {
      status_type                status;
      logic signed [VALUE_W-1:0] value;
      logic [DEPTH_W-1:0]        depth;
   } calc_result_type;

   logic clock;
   logic reset;

   rsc_req_if req_ch ();
   rsc_rsp_if rsp_ch ();

   rpn_stack_calculator_core u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // Shadow copy of the calculator stack
   logic [DATA_WIDTH-1:0] stack_mem [STACK_DEPTH];
   int                    stack_cnt;

   // Result words still owed by the core, oldest first
   calc_result_type rpn_results [$];

   int          mismatch_cnt;
   int          items_sent;
   int          burst_left;
   bit          tx_steady;
   bit          tx_valid_high;
   int unsigned hold_off_left;
   int          rx_mode;
   int          rx_phase_left;

   // Clock generation
   initial begin
      clock = 1'b0;
   end

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Compute the result word of one character and update the shadow stack
   function automatic calc_result_type rpn_eval(input logic [CHAR_W-1:0] ch);
      calc_result_type       res;
      logic [DATA_WIDTH-1:0] a;
      logic [DATA_WIDTH-1:0] b;
      logic [DATA_WIDTH-1:0] r;
      longint                n;
      longint                d;
      logic [63:0]           nm;
      logic [63:0]           dm;
      logic [63:0]           q;
      res.status = STAT_OK;
      res.value  = '0;
      r          = '0;
      if (ch >= CH_ZERO && ch <= CH_NINE) begin
         if (stack_cnt >= STACK_DEPTH) begin
            res.status = STAT_OVER;
         end else begin
            stack_mem[stack_cnt] = DATA_WIDTH'(ch - CH_ZERO);
            stack_cnt++;
         end
      end else begin
         case (ch)
            CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH: begin
               if (stack_cnt < 2) begin
                  res.status = STAT_UNDER;
               end else begin
                  a = stack_mem[stack_cnt-1];
                  b = stack_mem[stack_cnt-2];
                  case (ch)
                     CH_PLUS:  r = b + a;
                     CH_MINUS: r = b - a;
                     CH_STAR:  r = b * a;
                     default: begin
                        if (a == '0) begin
                           res.status = STAT_DIVZERO;
                        end else begin
                           // divide magnitudes, then fix the sign (truncate toward zero)
                           n  = $signed(b);
                           d  = $signed(a);
                           nm = (n < 0) ? -n : n;
                           dm = (d < 0) ? -d : d;
                           q  = nm / dm;
                           if ((n < 0) != (d < 0)) q = -q;
                           r  = q[DATA_WIDTH-1:0];
                        end
                     end
                  endcase
                  if (res.status == STAT_OK) begin
                     stack_cnt--;
                     stack_mem[stack_cnt-1] = r;
                  end
               end
            end
            CH_EQUAL: begin
               if (stack_cnt == 0) begin
                  res.status = STAT_UNDER;
               end else begin
                  stack_cnt--;
                  res.status = STAT_VALUE;
                  res.value  = VALUE_W'($signed(stack_mem[stack_cnt]));
               end
            end
            default: begin
               stack_cnt  = 0;
               res.status = STAT_END;
            end
         endcase
      end
      res.depth = DEPTH_W'(stack_cnt);
      return res;
   endfunction

   // Offer one character, wait for acceptance, then maybe idle between bursts
   task automatic send_char(input logic [CHAR_W-1:0] ch);
      int gap;
      req_ch.valid     <= 1'b1;
      req_ch.char_code <= ch;
      tx_valid_high     = 1'b1;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      rpn_results.push_back(rpn_eval(ch));
      items_sent++;
      if (!tx_steady) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap        = $urandom_range(0, 8);
            if (gap != 0) begin
               req_ch.valid <= 1'b0;
               tx_valid_high = 1'b0;
               repeat (gap) @(posedge clock);
            end
         end else begin
            burst_left--;
         end
      end
   endtask

   // Drop valid and hold until every owed result word has arrived
   task automatic wait_results_drained();
      if (tx_valid_high) begin
         req_ch.valid <= 1'b0;
         tx_valid_high = 1'b0;
      end
      while (rpn_results.size() != 0) @(posedge clock);
   endtask

   function automatic logic [CHAR_W-1:0] rand_digit(input int lo);
      return CHAR_W'(CH_ZERO + $urandom_range(lo, 9));
   endfunction

   // Pick a character that is neither a digit nor an operator nor '='
   function automatic logic [CHAR_W-1:0] rand_end_char();
      logic [CHAR_W-1:0] ch;
      do begin
         ch = CHAR_W'($urandom_range(0, 255));
      end while ((ch >= CH_ZERO && ch <= CH_NINE) || ch == CH_PLUS || ch == CH_MINUS ||
                 ch == CH_STAR || ch == CH_SLASH || ch == CH_EQUAL);
      return ch;
   endfunction

   // Underflow, divide by zero, every operator, report and end characters
   task automatic test_directed_ops();
      send_char(CH_EQUAL);
      send_char(CH_SLASH);
      send_char(CH_NINE);
      send_char(CH_PLUS);
      send_char(CH_ZERO);
      send_char(CH_SLASH);
      send_char(CH_PLUS);
      send_char(CHAR_W'(CH_ZERO + 7));
      send_char(CH_STAR);
      send_char(CHAR_W'(CH_ZERO + 5));
      send_char(CH_MINUS);
      send_char(CHAR_W'(CH_ZERO + 4));
      send_char(CH_SLASH);
      send_char(CH_EQUAL);
      send_char(CH_ZERO);
      send_char(8'h00);
      send_char(8'hFF);
   endtask

   // Build the most negative value, then divide it by minus one
   task automatic test_most_negative();
      send_char(CHAR_W'(CH_ZERO + 8));
      repeat (9) begin
         send_char(CHAR_W'(CH_ZERO + 8));
         send_char(CH_STAR);
      end
      send_char(CHAR_W'(CH_ZERO + 2));
      send_char(CH_STAR);
      send_char(CH_ZERO);
      send_char(CHAR_W'(CH_ZERO + 1));
      send_char(CH_MINUS);
      send_char(CH_SLASH);
      send_char(CH_EQUAL);
   endtask

   // Fill the stack, push past the top, then work at the full boundary
   task automatic test_full_stack();
      repeat (STACK_DEPTH) send_char(rand_digit(0));
      send_char(CH_NINE);
      send_char(CH_ZERO);
      send_char(CH_EQUAL);
      send_char(CH_NINE);
      send_char(CH_ZERO);
      send_char(CH_PLUS);
      send_char(CH_STAR);
      send_char(rand_end_char());
   endtask

   // Stall the receiver for a long stretch while words keep coming, then pause
   task automatic test_backpressure();
      hold_off_left = 400;
      repeat (24) send_char(($urandom_range(0, 2) == 0) ? CH_PLUS : rand_digit(0));
      send_char(CH_EQUAL);
      wait_results_drained();
      repeat (10) send_char(($urandom_range(0, 1) == 0) ? CH_STAR : rand_digit(1));
      send_char(rand_end_char());
   endtask

   // One well-formed expression with random operands and operators
   task automatic send_expression();
      int n_operands;
      int pick;
      n_operands = $urandom_range(1, 6);
      send_char(rand_digit(0));
      for (int i = 1; i < n_operands; i++) begin
         pick = $urandom_range(0, 3);
         case (pick)
            0: begin
               send_char(rand_digit(0));
               send_char(CH_PLUS);
            end
            1: begin
               send_char(rand_digit(0));
               send_char(CH_MINUS);
            end
            2: begin
               send_char(rand_digit(0));
               send_char(CH_STAR);
            end
            default: begin
               send_char(($urandom_range(0, 9) == 0) ? CH_ZERO : rand_digit(1));
               send_char(CH_SLASH);
            end
         endcase
      end
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
         send_char(CH_EQUAL);
      end else if (pick < 8) begin
         send_char(rand_end_char());
      end
   endtask

   // Mostly expressions, some raw noise, with a stretch of back-to-back words
   task automatic test_random_expressions();
      int start_cnt;
      start_cnt = items_sent;
      while (items_sent < 850) begin
         tx_steady = (items_sent - start_cnt) > 150 && (items_sent - start_cnt) < 260;
         if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 4)) send_char(CHAR_W'($urandom_range(0, 255)));
         end else begin
            send_expression();
         end
      end
      tx_steady = 1'b0;
   endtask

   // Receiver: long hold-off when asked, otherwise a changing stall pattern
   always @(posedge clock) begin
      if (hold_off_left != 0) begin
         rsp_ch.ready <= 1'b0;
         hold_off_left--;
      end else begin
         if (rx_phase_left == 0) begin
            rx_mode       = $urandom_range(0, 3);
            rx_phase_left = $urandom_range(16, 96);
         end else begin
            rx_phase_left--;
         end
         case (rx_mode)
            0:       rsp_ch.ready <= 1'b1;
            1:       rsp_ch.ready <= ($urandom_range(0, 3) != 0);
            2:       rsp_ch.ready <= ($urandom_range(0, 3) == 0);
            default: rsp_ch.ready <= rx_phase_left[0];
         endcase
      end
   end

   // Check each accepted result word against the oldest prediction
   always @(posedge clock) begin
      calc_result_type exp_res;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (rpn_results.size() == 0) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
               $display("unexpected word: status %0d value %0d depth %0d",
                        rsp_ch.status, rsp_ch.value, rsp_ch.depth);
         end else begin
            exp_res = rpn_results.pop_front();
            if (rsp_ch.status !== exp_res.status || rsp_ch.value !== exp_res.value ||
                rsp_ch.depth !== exp_res.depth) begin
               mismatch_cnt++;
               if (mismatch_cnt <= 10)
                  $display("mismatch: expected status %0d value %0d depth %0d, got %0d %0d %0d",
                           exp_res.status, exp_res.value, exp_res.depth,
                           rsp_ch.status, rsp_ch.value, rsp_ch.depth);
            end
         end
      end
   end

   // Stimulus sequence
   initial begin
      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.char_code = '0;
      rsp_ch.ready     = 1'b0;
      stack_cnt        = 0;
      mismatch_cnt     = 0;
      items_sent       = 0;
      burst_left       = 0;
      tx_steady        = 1'b0;
      tx_valid_high    = 1'b0;
      hold_off_left    = 0;
      rx_mode          = 0;
      rx_phase_left    = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_directed_ops();
      test_most_negative();
      test_full_stack();
      test_backpressure();
      test_random_expressions();
      wait_results_drained();
      repeat (64) @(posedge clock);
      if (mismatch_cnt == 0 && rpn_results.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #(10_000_000);
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/rsc_pkg.sv
hdl/rsc_if.sv
hdl/rsc_ram.sv
hdl/rsc_alu.sv
hdl/rpn_stack_calculator_core.sv
sim/tb.sv
